// ===== rtl/core/tvne_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tvne_pkg
// Shared types and constants of the triangle vertex normal engine: command
// codes, controller states, and the command and status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package tvne_pkg;

  // defaults of the top level parameters
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int COORD_WIDTH_DEF  = 24;

  // fixed field widths
  localparam int IDX_W  = 10;
  localparam int POS_W  = 24;
  localparam int NORM_W = 16;
  localparam int SUM_W  = 26;

  // arithmetic widths
  localparam int MUL_W   = 31;  // signed multiplier operand
  localparam int PROD_W  = 62;  // signed multiplier product
  localparam int MAG_W   = 62;  // component magnitude
  localparam int MAG_LIM = 30;  // magnitudes are brought below 2^30
  localparam int SQ_W    = 62;  // sum of squares
  localparam int ROOT_W  = 63;  // root register with headroom
  localparam int LEN_W   = 32;  // vector length
  localparam int QUO_W   = 17;  // quotient bits of one division
  localparam int NUM_W   = 48;  // dividend width
  localparam int REM_W   = 34;  // partial remainder width
  localparam int STEP_W  = 5;   // controller step counter

  // sequencing lengths
  localparam int CROSS_STEPS = 6;
  localparam int AXES        = 3;
  localparam int SQRT_STEPS  = 31;
  localparam int DIV_STEPS   = QUO_W;

  // largest normal component, Q1.15
  localparam int NORM_MAX = 32767;

  // request commands
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_ADD   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // controller states
  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_DIFF,
    ST_MUL,
    ST_ACC,
    ST_SUM_RD,
    ST_SUM_LD,
    ST_SHIFT,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_ROOT_CHK,
    ST_SQRT,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_STORE,
    ST_EMIT,
    ST_EMIT_ZERO,
    ST_UPD_RD,
    ST_UPD_WR
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic       latch;
    logic       vtx_wr;
    logic [1:0] rd_sel;
    logic       cap_a;
    logic       cap_b;
    logic       ld_diff;
    logic       mul_go;
    logic       mul_sq;
    logic       acc_cross;
    logic [2:0] step;
    logic       ld_sum;
    logic       shift;
    logic       sq_clr;
    logic       sq_acc;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       div_store;
    logic [1:0] comp;
    logic       out_load;
    logic       out_zero;
    logic       sum_wr;
    logic       clr_wr;
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    op_t  op;
    logic idx_ok;
    logic need_shift;
    logic sum_zero;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/tvne_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tvne_ctrl
// Sequencer of the engine: takes one request at a time and steps the
// datapath through fetch, cross product, normalization and sum update.
// ----------------------------------------------------------------------------
module tvne_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire tvne_pkg::sts_t sts,
  output tvne_pkg::ctl_t     ctl
);

  tvne_pkg::state_t              state, state_next;
  logic [tvne_pkg::STEP_W-1:0]   cnt, cnt_next;
  logic [1:0]                    comp, comp_next;

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tvne_pkg::ST_CLEAR;
      cnt   <= '0;
      comp  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      comp  <= comp_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    comp_next  = comp;
    unique case (state)
      tvne_pkg::ST_CLEAR: begin
        if (sts.clr_last) state_next = tvne_pkg::ST_IDLE;
      end
      tvne_pkg::ST_IDLE: begin
        if (in_valid) state_next = tvne_pkg::ST_DECODE;
      end
      tvne_pkg::ST_DECODE: begin
        cnt_next  = '0;
        comp_next = '0;
        unique case (sts.op)
          tvne_pkg::OP_WRITE: state_next = tvne_pkg::ST_IDLE;
          tvne_pkg::OP_CLEAR: state_next = tvne_pkg::ST_CLEAR;
          tvne_pkg::OP_READ:
            state_next = sts.idx_ok ? tvne_pkg::ST_SUM_RD : tvne_pkg::ST_EMIT_ZERO;
          tvne_pkg::OP_ADD:
            state_next = sts.idx_ok ? tvne_pkg::ST_RD_A : tvne_pkg::ST_EMIT_ZERO;
          default: state_next = tvne_pkg::ST_IDLE;
        endcase
      end
      tvne_pkg::ST_RD_A:   state_next = tvne_pkg::ST_RD_B;
      tvne_pkg::ST_RD_B:   state_next = tvne_pkg::ST_RD_C;
      tvne_pkg::ST_RD_C:   state_next = tvne_pkg::ST_DIFF;
      tvne_pkg::ST_DIFF:   state_next = tvne_pkg::ST_MUL;
      tvne_pkg::ST_MUL:    state_next = tvne_pkg::ST_ACC;
      tvne_pkg::ST_ACC: begin
        if (cnt == tvne_pkg::STEP_W'(tvne_pkg::CROSS_STEPS - 1)) begin
          state_next = tvne_pkg::ST_SHIFT;
          cnt_next   = '0;
        end else begin
          state_next = tvne_pkg::ST_MUL;
          cnt_next   = cnt + 1'b1;
        end
      end
      tvne_pkg::ST_SUM_RD: state_next = tvne_pkg::ST_SUM_LD;
      tvne_pkg::ST_SUM_LD: state_next = tvne_pkg::ST_SHIFT;
      tvne_pkg::ST_SHIFT: begin
        if (!sts.need_shift) begin
          state_next = tvne_pkg::ST_SQ_MUL;
          cnt_next   = '0;
        end
      end
      tvne_pkg::ST_SQ_MUL: state_next = tvne_pkg::ST_SQ_ACC;
      tvne_pkg::ST_SQ_ACC: begin
        if (cnt == tvne_pkg::STEP_W'(tvne_pkg::AXES - 1)) begin
          state_next = tvne_pkg::ST_ROOT_CHK;
          cnt_next   = '0;
        end else begin
          state_next = tvne_pkg::ST_SQ_MUL;
          cnt_next   = cnt + 1'b1;
        end
      end
      tvne_pkg::ST_ROOT_CHK: begin
        cnt_next   = '0;
        state_next = sts.sum_zero ? tvne_pkg::ST_EMIT_ZERO : tvne_pkg::ST_SQRT;
      end
      tvne_pkg::ST_SQRT: begin
        if (cnt == tvne_pkg::STEP_W'(tvne_pkg::SQRT_STEPS - 1)) begin
          state_next = tvne_pkg::ST_DIV_INIT;
          cnt_next   = '0;
          comp_next  = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      tvne_pkg::ST_DIV_INIT: begin
        state_next = tvne_pkg::ST_DIV;
        cnt_next   = '0;
      end
      tvne_pkg::ST_DIV: begin
        if (cnt == tvne_pkg::STEP_W'(tvne_pkg::DIV_STEPS - 1)) begin
          state_next = tvne_pkg::ST_DIV_STORE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      tvne_pkg::ST_DIV_STORE: begin
        if (comp == 2'(tvne_pkg::AXES - 1)) begin
          state_next = tvne_pkg::ST_EMIT;
          comp_next  = '0;
        end else begin
          state_next = tvne_pkg::ST_DIV_INIT;
          comp_next  = comp + 1'b1;
        end
      end
      tvne_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          state_next = (sts.op == tvne_pkg::OP_ADD) ? tvne_pkg::ST_UPD_RD
                                                    : tvne_pkg::ST_IDLE;
          comp_next  = '0;
        end
      end
      tvne_pkg::ST_EMIT_ZERO: begin
        if (sts.out_free) state_next = tvne_pkg::ST_IDLE;
      end
      tvne_pkg::ST_UPD_RD: state_next = tvne_pkg::ST_UPD_WR;
      tvne_pkg::ST_UPD_WR: begin
        if (comp == 2'(tvne_pkg::AXES - 1)) begin
          state_next = tvne_pkg::ST_IDLE;
          comp_next  = '0;
        end else begin
          state_next = tvne_pkg::ST_UPD_RD;
          comp_next  = comp + 1'b1;
        end
      end
      default: state_next = tvne_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    ctl        = '0;
    ctl.step   = cnt[2:0];
    ctl.comp   = comp;
    ctl.rd_sel = comp;
    in_ready   = 1'b0;
    unique case (state)
      tvne_pkg::ST_CLEAR: ctl.clr_wr = 1'b1;
      tvne_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        ctl.latch = in_valid;
      end
      tvne_pkg::ST_DECODE: begin
        ctl.vtx_wr = (sts.op == tvne_pkg::OP_WRITE) && sts.idx_ok;
      end
      tvne_pkg::ST_RD_A: ctl.rd_sel = 2'd0;
      tvne_pkg::ST_RD_B: begin
        ctl.rd_sel = 2'd1;
        ctl.cap_a  = 1'b1;
      end
      tvne_pkg::ST_RD_C: begin
        ctl.rd_sel = 2'd2;
        ctl.cap_b  = 1'b1;
      end
      tvne_pkg::ST_DIFF:   ctl.ld_diff = 1'b1;
      tvne_pkg::ST_MUL:    ctl.mul_go = 1'b1;
      tvne_pkg::ST_ACC:    ctl.acc_cross = 1'b1;
      tvne_pkg::ST_SUM_RD: ctl.rd_sel = 2'd0;
      tvne_pkg::ST_SUM_LD: ctl.ld_sum = 1'b1;
      tvne_pkg::ST_SHIFT: begin
        ctl.shift  = sts.need_shift;
        ctl.sq_clr = !sts.need_shift;
      end
      tvne_pkg::ST_SQ_MUL: begin
        ctl.mul_go = 1'b1;
        ctl.mul_sq = 1'b1;
      end
      tvne_pkg::ST_SQ_ACC:    ctl.sq_acc = 1'b1;
      tvne_pkg::ST_ROOT_CHK:  ctl.sqrt_init = 1'b1;
      tvne_pkg::ST_SQRT:      ctl.sqrt_step = 1'b1;
      tvne_pkg::ST_DIV_INIT:  ctl.div_init = 1'b1;
      tvne_pkg::ST_DIV:       ctl.div_step = 1'b1;
      tvne_pkg::ST_DIV_STORE: ctl.div_store = 1'b1;
      tvne_pkg::ST_EMIT:      ctl.out_load = sts.out_free;
      tvne_pkg::ST_EMIT_ZERO: begin
        ctl.out_load = sts.out_free;
        ctl.out_zero = 1'b1;
      end
      tvne_pkg::ST_UPD_RD: ctl.rd_sel = comp;
      tvne_pkg::ST_UPD_WR: ctl.sum_wr = 1'b1;
      default: ctl = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/tvne_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tvne_dpath
// Datapath of the engine: vertex and normal sum memories, a shared
// multiplier, the root and divider units and the result register.
// ----------------------------------------------------------------------------
module tvne_dpath #(
  parameter int MAX_VERTICES = tvne_pkg::MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = tvne_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire tvne_pkg::ctl_t                     ctl,
  output tvne_pkg::sts_t                          sts,
  input  wire logic [1:0]                         cmd,
  input  wire logic [tvne_pkg::IDX_W-1:0]         index,
  input  wire logic [tvne_pkg::IDX_W-1:0]         corner_b,
  input  wire logic [tvne_pkg::IDX_W-1:0]         corner_c,
  input  wire logic signed [tvne_pkg::POS_W-1:0]  pos_x,
  input  wire logic signed [tvne_pkg::POS_W-1:0]  pos_y,
  input  wire logic signed [tvne_pkg::POS_W-1:0]  pos_z,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    kind,
  output logic signed [tvne_pkg::NORM_W-1:0]      norm_x,
  output logic signed [tvne_pkg::NORM_W-1:0]      norm_y,
  output logic signed [tvne_pkg::NORM_W-1:0]      norm_z,
  output logic                                    degenerate
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = COORD_WIDTH;
  localparam int DW = COORD_WIDTH + 1;
  localparam int DS = (COORD_WIDTH > 29) ? (COORD_WIDTH - 29) : 0;
  localparam int IW = tvne_pkg::IDX_W;
  localparam int SW = tvne_pkg::SUM_W;
  localparam int NW = tvne_pkg::NORM_W;
  localparam int MW = tvne_pkg::MUL_W;
  localparam int PW = tvne_pkg::PROD_W;
  localparam int GW = tvne_pkg::MAG_W;

  // index range check
  function automatic logic in_rng(logic [IW-1:0] idx);
    return 32'(idx) < MAX_VERTICES;
  endfunction

  // difference magnitude scaled down, sign put back
  function automatic logic signed [MW-1:0] shrink(logic signed [DW-1:0] d);
    logic [DW-1:0] mg;
    logic [MW-1:0] sm;
    mg = d[DW-1] ? (~d + 1'b1) : d;
    sm = MW'(mg >> DS);
    return d[DW-1] ? -$signed(sm) : $signed(sm);
  endfunction

  // saturating add of a normal component to a sum
  function automatic logic signed [SW-1:0] sat_add(logic signed [SW-1:0] s,
                                                   logic signed [NW-1:0] n);
    logic signed [SW:0] t;
    t = (SW+1)'(s) + (SW+1)'(n);
    if (t[SW] != t[SW-1]) begin
      return t[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end
    return t[SW-1:0];
  endfunction

  // latched request
  tvne_pkg::op_t          op_q;
  logic [IW-1:0]          a_q, b_q, c_q;
  logic signed [CW-1:0]   px, py, pz;

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      op_q <= tvne_pkg::op_t'(cmd);
      a_q  <= index;
      b_q  <= corner_b;
      c_q  <= corner_c;
      px   <= CW'(pos_x);
      py   <= CW'(pos_y);
      pz   <= CW'(pos_z);
    end
  end

  // shared memory address
  logic [IW-1:0] sel_idx;
  logic [AW-1:0] addr;

  always_comb begin
    unique case (ctl.rd_sel)
      2'd0:    sel_idx = a_q;
      2'd1:    sel_idx = b_q;
      default: sel_idx = c_q;
    endcase
    addr = AW'(sel_idx);
  end

  // vertex position memories
  logic signed [CW-1:0] vmem_x [MAX_VERTICES];
  logic signed [CW-1:0] vmem_y [MAX_VERTICES];
  logic signed [CW-1:0] vmem_z [MAX_VERTICES];
  logic signed [CW-1:0] vrd_x, vrd_y, vrd_z;
  logic [AW-1:0]        vwa;

  assign vwa = AW'(a_q);

  always_ff @(posedge clk) begin
    if (ctl.vtx_wr) begin
      vmem_x[vwa] <= px;
      vmem_y[vwa] <= py;
      vmem_z[vwa] <= pz;
    end
    vrd_x <= vmem_x[addr];
    vrd_y <= vmem_y[addr];
    vrd_z <= vmem_z[addr];
  end

  // normal sum memories
  logic signed [SW-1:0] smem_x [MAX_VERTICES];
  logic signed [SW-1:0] smem_y [MAX_VERTICES];
  logic signed [SW-1:0] smem_z [MAX_VERTICES];
  logic signed [SW-1:0] srd_x, srd_y, srd_z;
  logic signed [SW-1:0] swd_x, swd_y, swd_z;
  logic [AW-1:0]        clr_addr;
  logic [AW-1:0]        swa;
  logic                 swe;
  logic signed [NW-1:0] res_x, res_y, res_z;

  always_comb begin
    swe = ctl.sum_wr || ctl.clr_wr;
    if (ctl.clr_wr) begin
      swa   = clr_addr;
      swd_x = '0;
      swd_y = '0;
      swd_z = '0;
    end else begin
      swa   = addr;
      swd_x = sat_add(srd_x, res_x);
      swd_y = sat_add(srd_y, res_y);
      swd_z = sat_add(srd_z, res_z);
    end
  end

  always_ff @(posedge clk) begin
    if (swe) begin
      smem_x[swa] <= swd_x;
      smem_y[swa] <= swd_y;
      smem_z[swa] <= swd_z;
    end
    srd_x <= smem_x[addr];
    srd_y <= smem_y[addr];
    srd_z <= smem_z[addr];
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl.clr_wr) begin
      clr_addr <= sts.clr_last ? '0 : clr_addr + 1'b1;
    end
  end

  // corner capture and shrunk edge vectors
  logic signed [CW-1:0] va_x, va_y, va_z, vb_x, vb_y, vb_z;
  logic signed [MW-1:0] e1x, e1y, e1z, e2x, e2y, e2z;

  always_ff @(posedge clk) begin
    if (ctl.cap_a) begin
      va_x <= vrd_x;
      va_y <= vrd_y;
      va_z <= vrd_z;
    end
    if (ctl.cap_b) begin
      vb_x <= vrd_x;
      vb_y <= vrd_y;
      vb_z <= vrd_z;
    end
    if (ctl.ld_diff) begin
      e1x <= shrink(DW'(vb_x) - DW'(va_x));
      e1y <= shrink(DW'(vb_y) - DW'(va_y));
      e1z <= shrink(DW'(vb_z) - DW'(va_z));
      e2x <= shrink(DW'(vrd_x) - DW'(va_x));
      e2y <= shrink(DW'(vrd_y) - DW'(va_y));
      e2z <= shrink(DW'(vrd_z) - DW'(va_z));
    end
  end

  // component magnitudes and signs
  logic [GW-1:0] mag_x, mag_y, mag_z;
  logic          sgn_x, sgn_y, sgn_z;
  logic [GW-1:0] mag_sq, mag_dv;
  logic          sgn_dv;

  always_comb begin
    unique case (ctl.step[1:0])
      2'd0:    mag_sq = mag_x;
      2'd1:    mag_sq = mag_y;
      default: mag_sq = mag_z;
    endcase
    unique case (ctl.comp)
      2'd0: begin
        mag_dv = mag_x;
        sgn_dv = sgn_x;
      end
      2'd1: begin
        mag_dv = mag_y;
        sgn_dv = sgn_y;
      end
      default: begin
        mag_dv = mag_z;
        sgn_dv = sgn_z;
      end
    endcase
  end

  // shared multiplier operands
  logic signed [MW-1:0] opa, opb;
  logic signed [PW-1:0] prod, acc;

  always_comb begin
    if (ctl.mul_sq) begin
      opa = $signed(MW'(mag_sq));
      opb = $signed(MW'(mag_sq));
    end else begin
      unique case (ctl.step)
        3'd0:    begin opa = e1y; opb = e2z; end
        3'd1:    begin opa = e1z; opb = e2y; end
        3'd2:    begin opa = e1z; opb = e2x; end
        3'd3:    begin opa = e1x; opb = e2z; end
        3'd4:    begin opa = e1x; opb = e2y; end
        default: begin opa = e1y; opb = e2x; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_go) prod <= opa * opb;
  end

  // cross product difference of the product pair
  logic signed [PW:0] cv;
  logic [GW-1:0]      cv_mag;

  always_comb begin
    cv     = (PW+1)'(acc) - (PW+1)'(prod);
    cv_mag = cv[PW] ? GW'(-cv) : GW'(cv);
  end

  // magnitude loading, cross accumulate and range shift
  always_ff @(posedge clk) begin
    if (ctl.acc_cross) begin
      if (!ctl.step[0]) begin
        acc <= prod;
      end else begin
        unique case (ctl.step[2:1])
          2'd0: begin
            mag_x <= cv_mag;
            sgn_x <= cv[PW];
          end
          2'd1: begin
            mag_y <= cv_mag;
            sgn_y <= cv[PW];
          end
          default: begin
            mag_z <= cv_mag;
            sgn_z <= cv[PW];
          end
        endcase
      end
    end else if (ctl.ld_sum) begin
      // one extra bit so that the most negative sum negates cleanly
      mag_x <= srd_x[SW-1] ? GW'(-(SW+1)'(srd_x)) : GW'(srd_x);
      mag_y <= srd_y[SW-1] ? GW'(-(SW+1)'(srd_y)) : GW'(srd_y);
      mag_z <= srd_z[SW-1] ? GW'(-(SW+1)'(srd_z)) : GW'(srd_z);
      sgn_x <= srd_x[SW-1];
      sgn_y <= srd_y[SW-1];
      sgn_z <= srd_z[SW-1];
    end else if (ctl.shift) begin
      mag_x <= mag_x >> 1;
      mag_y <= mag_y >> 1;
      mag_z <= mag_z >> 1;
    end
  end

  // sum of squares
  logic [tvne_pkg::SQ_W-1:0] sumsq;

  always_ff @(posedge clk) begin
    if (ctl.sq_clr) begin
      sumsq <= '0;
    end else if (ctl.sq_acc) begin
      sumsq <= sumsq + tvne_pkg::SQ_W'(prod);
    end
  end

  // bitwise integer square root, two radicand bits a step
  logic [tvne_pkg::SQ_W-1:0]   sq_x, sq_bit;
  logic [tvne_pkg::ROOT_W-1:0] sq_r, sq_t;

  assign sq_t = sq_r + tvne_pkg::ROOT_W'(sq_bit);

  always_ff @(posedge clk) begin
    if (ctl.sqrt_init) begin
      sq_x   <= sumsq;
      sq_r   <= '0;
      sq_bit <= tvne_pkg::SQ_W'(1) << (tvne_pkg::SQ_W - 2);
    end else if (ctl.sqrt_step) begin
      if (tvne_pkg::ROOT_W'(sq_x) >= sq_t) begin
        sq_x <= sq_x - tvne_pkg::SQ_W'(sq_t);
        sq_r <= (sq_r >> 1) + tvne_pkg::ROOT_W'(sq_bit);
      end else begin
        sq_r <= sq_r >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  // restoring divider, one quotient bit a step
  logic [tvne_pkg::LEN_W-1:0] len;
  logic [tvne_pkg::LEN_W:0]   dv;
  logic [tvne_pkg::NUM_W-1:0] nume;
  logic [tvne_pkg::REM_W-1:0] rem, rem_t;
  logic [tvne_pkg::QUO_W-1:0] num, quo;

  always_comb begin
    len   = tvne_pkg::LEN_W'(sq_r);
    dv    = {len, 1'b0};
    nume  = (tvne_pkg::NUM_W'(mag_dv) << 16) + tvne_pkg::NUM_W'(len);
    rem_t = {rem[tvne_pkg::REM_W-2:0], num[tvne_pkg::QUO_W-1]};
  end

  always_ff @(posedge clk) begin
    if (ctl.div_init) begin
      rem <= tvne_pkg::REM_W'(nume >> tvne_pkg::QUO_W);
      num <= nume[tvne_pkg::QUO_W-1:0];
      quo <= '0;
    end else if (ctl.div_step) begin
      if (rem_t >= tvne_pkg::REM_W'(dv)) begin
        rem <= rem_t - tvne_pkg::REM_W'(dv);
        quo <= {quo[tvne_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem <= rem_t;
        quo <= {quo[tvne_pkg::QUO_W-2:0], 1'b0};
      end
      num <= {num[tvne_pkg::QUO_W-2:0], 1'b0};
    end
  end

  // saturate, restore sign and store the component
  logic [NW-1:0]        q_sat;
  logic signed [NW-1:0] q_res;

  always_comb begin
    q_sat = (quo > tvne_pkg::QUO_W'(tvne_pkg::NORM_MAX)) ? NW'(tvne_pkg::NORM_MAX)
                                                         : NW'(quo);
    q_res = sgn_dv ? -$signed(q_sat) : $signed(q_sat);
  end

  always_ff @(posedge clk) begin
    if (ctl.div_store) begin
      unique case (ctl.comp)
        2'd0:    res_x <= q_res;
        2'd1:    res_y <= q_res;
        default: res_z <= q_res;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      kind       <= (op_q == tvne_pkg::OP_READ);
      degenerate <= ctl.out_zero;
      norm_x     <= ctl.out_zero ? '0 : res_x;
      norm_y     <= ctl.out_zero ? '0 : res_y;
      norm_z     <= ctl.out_zero ? '0 : res_z;
    end
  end

  // status back to the sequencer
  always_comb begin
    sts.op         = op_q;
    sts.idx_ok     = (op_q == tvne_pkg::OP_ADD) ? (in_rng(a_q) && in_rng(b_q) && in_rng(c_q))
                                                : in_rng(a_q);
    sts.need_shift = (|mag_x[GW-1:tvne_pkg::MAG_LIM]) || (|mag_y[GW-1:tvne_pkg::MAG_LIM]) ||
                     (|mag_z[GW-1:tvne_pkg::MAG_LIM]);
    sts.sum_zero   = (sumsq == '0);
    sts.clr_last   = (clr_addr == AW'(MAX_VERTICES - 1));
    sts.out_free   = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

// ===== rtl/core/triangle_vertex_normal_engine_core.sv =====
`default_nettype none
// A vertex normal read or an added triangle shifts its vector right one bit at
// a time while it exceeds 30 bits, then runs the 31-step root and three
// divisions before the result loads; an added triangle then updates the sum
// of each corner. A clear runs a pass over all entries. One request at a
// time. Reset starts a clearing pass of MAX_VERTICES entries with in_ready
// low; vertex positions undefined until written.
// ----------------------------------------------------------------------------
// triangle_vertex_normal_engine_core
// Vertex normal engine: stores vertex positions, computes unit face normals
// of triangles, accumulates them per vertex and returns normalized sums.
// ----------------------------------------------------------------------------
module triangle_vertex_normal_engine_core #(
  parameter int MAX_VERTICES = tvne_pkg::MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = tvne_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        cmd,
  input  wire logic [tvne_pkg::IDX_W-1:0]        index,
  input  wire logic [tvne_pkg::IDX_W-1:0]        corner_b,
  input  wire logic [tvne_pkg::IDX_W-1:0]        corner_c,
  input  wire logic signed [tvne_pkg::POS_W-1:0] pos_x,
  input  wire logic signed [tvne_pkg::POS_W-1:0] pos_y,
  input  wire logic signed [tvne_pkg::POS_W-1:0] pos_z,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   kind,
  output logic signed [tvne_pkg::NORM_W-1:0]     norm_x,
  output logic signed [tvne_pkg::NORM_W-1:0]     norm_y,
  output logic signed [tvne_pkg::NORM_W-1:0]     norm_z,
  output logic                                   degenerate
);

  tvne_pkg::ctl_t ctl;
  tvne_pkg::sts_t sts;

  // sequencer
  tvne_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // memories and arithmetic
  tvne_dpath #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .cmd        (cmd),
    .index      (index),
    .corner_b   (corner_b),
    .corner_c   (corner_c),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .norm_x     (norm_x),
    .norm_y     (norm_y),
    .norm_z     (norm_z),
    .degenerate (degenerate)
  );

endmodule
`default_nettype wire

// ===== test/tb_triangle_vertex_normal_engine_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_triangle_vertex_normal_engine_core
// Self-checking bench for the vertex normal engine. A short directed table
// covers reset state, extreme coordinates, degenerate faces and clearing. A
// long run of one triangle drives a normal sum into saturation. Random
// traffic follows, with triangles built only from written vertices. Every
// result is checked against a table entry or a model of the stores and the
// fixed-point normalization, under changing request and result stalls.
// ----------------------------------------------------------------------------
module tb_triangle_vertex_normal_engine_core;

  localparam int NVTX      = 1024;
  localparam int SUM_HI    = 33554431;
  localparam int SUM_LO    = -33554432;
  localparam int SAT_ADDS  = 1030;
  localparam int RAND_REQS = 800;
  localparam int LIMIT     = 3000000;
  localparam int N_DIR     = 20;

  typedef struct {
    logic              kind;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic              deg;
  } normal_t;

  typedef struct {
    tvne_pkg::op_t op;
    int  a;
    int  b;
    int  c;
    int  px;
    int  py;
    int  pz;
    bit  typed;
    int  ekind;
    int  ex;
    int  ey;
    int  ez;
    int  edeg;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] cmd = tvne_pkg::OP_WRITE;
  logic [tvne_pkg::IDX_W-1:0] index = '0;
  logic [tvne_pkg::IDX_W-1:0] corner_b = '0;
  logic [tvne_pkg::IDX_W-1:0] corner_c = '0;
  logic signed [tvne_pkg::POS_W-1:0] pos_x = '0;
  logic signed [tvne_pkg::POS_W-1:0] pos_y = '0;
  logic signed [tvne_pkg::POS_W-1:0] pos_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic kind;
  logic signed [tvne_pkg::NORM_W-1:0] norm_x;
  logic signed [tvne_pkg::NORM_W-1:0] norm_y;
  logic signed [tvne_pkg::NORM_W-1:0] norm_z;
  logic degenerate;

  triangle_vertex_normal_engine_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .index(index), .corner_b(corner_b), .corner_c(corner_c),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
    .degenerate(degenerate)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // bench copy of the vertex and normal sum stores
  int vtx_x [NVTX];
  int vtx_y [NVTX];
  int vtx_z [NVTX];
  bit vtx_written [NVTX];
  int sum_x [NVTX];
  int sum_y [NVTX];
  int sum_z [NVTX];
  int written_list [$];

  normal_t pending_normals [$];
  int errors = 0;
  int cycles = 0;
  int snd_pct = 6;
  int rcv_pct = 52;
  int sent = 0;

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // fixed-point unit vector, rounded half away from zero, zero vector flagged
  function automatic normal_t unit_normal(logic k, longint cx, longint cy, longint cz);
    normal_t n;
    longint comp [3];
    longint unsigned m [3];
    longint unsigned mx = 0;
    longint unsigned sq = 0;
    longint unsigned len;
    longint unsigned q;
    int s = 0;
    logic signed [15:0] res [3];
    comp[0] = cx;
    comp[1] = cy;
    comp[2] = cz;
    n.kind = k;
    for (int i = 0; i < 3; i++) begin
      m[i] = comp[i] < 0 ? longint'(-comp[i]) : longint'(comp[i]);
      if (m[i] > mx) mx = m[i];
    end
    while ((mx >> s) >= (64'd1 << 30)) s++;
    for (int i = 0; i < 3; i++) begin
      m[i] >>= s;
      sq += m[i] * m[i];
    end
    if (sq == 0) begin
      n.nx = 0; n.ny = 0; n.nz = 0; n.deg = 1'b1;
      return n;
    end
    len = root_floor(sq);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 65536 + len) / (2 * len);
      if (q > 64'(tvne_pkg::NORM_MAX)) q = 64'(tvne_pkg::NORM_MAX);
      res[i] = comp[i] < 0 ? -16'(q) : 16'(q);
    end
    n.nx = res[0]; n.ny = res[1]; n.nz = res[2]; n.deg = 1'b0;
    return n;
  endfunction

  function automatic int sat_sum(int acc, int d);
    longint r = longint'(acc) + d;
    if (r > SUM_HI) r = SUM_HI;
    if (r < SUM_LO) r = SUM_LO;
    return int'(r);
  endfunction

  // updates the stores for one request; returns 1 when a result is due
  function automatic bit vertex_normal_step(tvne_pkg::op_t op, int a, int b, int c,
                                            int px, int py, int pz, output normal_t n);
    longint e1x, e1y, e1z, e2x, e2y, e2z;
    int corners [3];
    n = '{default: 0};
    case (op)
      tvne_pkg::OP_WRITE: begin
        vtx_x[a] = int'($signed(24'(px)));
        vtx_y[a] = int'($signed(24'(py)));
        vtx_z[a] = int'($signed(24'(pz)));
        if (!vtx_written[a]) written_list.insert(written_list.size(), a);
        vtx_written[a] = 1'b1;
        return 1'b0;
      end
      tvne_pkg::OP_CLEAR: begin
        for (int i = 0; i < NVTX; i++) begin
          sum_x[i] = 0; sum_y[i] = 0; sum_z[i] = 0;
        end
        return 1'b0;
      end
      tvne_pkg::OP_READ: begin
        n = unit_normal(1'b1, sum_x[a], sum_y[a], sum_z[a]);
        return 1'b1;
      end
      default: begin
        e1x = longint'(vtx_x[b]) - vtx_x[a];
        e1y = longint'(vtx_y[b]) - vtx_y[a];
        e1z = longint'(vtx_z[b]) - vtx_z[a];
        e2x = longint'(vtx_x[c]) - vtx_x[a];
        e2y = longint'(vtx_y[c]) - vtx_y[a];
        e2z = longint'(vtx_z[c]) - vtx_z[a];
        n = unit_normal(1'b0, e1y * e2z - e1z * e2y, e1z * e2x - e1x * e2z,
                        e1x * e2y - e1y * e2x);
        if (!n.deg) begin
          corners[0] = a; corners[1] = b; corners[2] = c;
          for (int i = 0; i < 3; i++) begin
            sum_x[corners[i]] = sat_sum(sum_x[corners[i]], n.nx);
            sum_y[corners[i]] = sat_sum(sum_y[corners[i]], n.ny);
            sum_z[corners[i]] = sat_sum(sum_z[corners[i]], n.nz);
          end
        end
        return 1'b1;
      end
    endcase
  endfunction

  // present one request, with optional idle gap, and record its result
  task automatic send_request(tvne_pkg::op_t op, int a, int b, int c, int px, int py,
                              int pz, bit typed, normal_t typed_n);
    normal_t n;
    bit go;
    int ph;
    ph = sent < 620 ? 0 : (sent < 1240 ? 1 : 2);
    if ((ph == 0 && sent == 0) || (sent == 620) || (sent == 1240)) begin
      snd_pct = ph == 0 ? 6 : (ph == 1 ? 52 : 0);
      rcv_pct = ph == 0 ? 52 : (ph == 1 ? 6 : 0);
    end
    if (sent == 620 || sent == 1240 || sent == 1600) begin
      // hold off until the engine has drained
      if (pending_normals.size() != 0) begin
        in_valid <= 1'b0;
        while (pending_normals.size() != 0) @(posedge clk);
      end
    end else if ($urandom_range(99) < snd_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    cmd <= op;
    index <= tvne_pkg::IDX_W'(a);
    corner_b <= tvne_pkg::IDX_W'(b);
    corner_c <= tvne_pkg::IDX_W'(c);
    pos_x <= tvne_pkg::POS_W'(px);
    pos_y <= tvne_pkg::POS_W'(py);
    pos_z <= tvne_pkg::POS_W'(pz);
    in_valid <= 1'b1;
    do begin
      @(negedge clk);
      go = in_ready;
      @(posedge clk);
    end while (!go);
    sent++;
    if (vertex_normal_step(op, a, b, c, px, py, pz, n))
      pending_normals.insert(pending_normals.size(), typed ? typed_n : n);
  endtask

  // result stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_pct);
  end

  // result check, sampled on the falling edge ahead of the accepting edge
  always @(negedge clk) begin
    normal_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_normals.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result kind=%0d", kind);
      end else begin
        e = pending_normals.pop_front();
        if (kind !== e.kind || norm_x !== e.nx || norm_y !== e.ny ||
            norm_z !== e.nz || degenerate !== e.deg) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp k=%0d n=(%0d,%0d,%0d) d=%0d got k=%0d n=(%0d,%0d,%0d) d=%0d",
                     e.kind, e.nx, e.ny, e.nz, e.deg,
                     kind, norm_x, norm_y, norm_z, degenerate);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_triangle_vertex_normal_engine_core NOT OK");
      $finish;
    end
  end

  // directed requests; typed results only where obvious
  dir_row_t dir_tab [N_DIR] = '{
    '{tvne_pkg::OP_READ,     0,    0, 0,        0,        0,     0, 1, 1, 0, 0,     0, 1},
    '{tvne_pkg::OP_READ,  1023,    0, 0,        0,        0,     0, 1, 1, 0, 0,     0, 1},
    '{tvne_pkg::OP_WRITE,    0,    0, 0,        0,        0,     0, 0, 0, 0, 0,     0, 0},
    '{tvne_pkg::OP_WRITE,    1,    0, 0,    65536,        0,     0, 0, 0, 0, 0,     0, 0},
    '{tvne_pkg::OP_WRITE,    2,    0, 0,        0,    65536,     0, 0, 0, 0, 0,     0, 0},
    '{tvne_pkg::OP_ADD,      0,    1, 2,        0,        0,     0, 1, 0, 0, 0, 32767, 0},
    '{tvne_pkg::OP_READ,     0,    0, 0,        0,        0,     0, 1, 1, 0, 0, 32767, 0},
    '{tvne_pkg::OP_WRITE, 1023,    0, 0,  8388607,  8388607, 8388607, 0, 0, 0, 0, 0, 0},
    '{tvne_pkg::OP_WRITE,    3,    0, 0, -8388608, -8388608, -8388608, 0, 0, 0, 0, 0, 0},
    '{tvne_pkg::OP_ADD,      0, 1023, 3,        0,        0,     0, 1, 0, 0, 0,     0, 1},
    '{tvne_pkg::OP_ADD,   1023,    3, 0,        0,        0,     0, 1, 0, 0, 0,     0, 1},
    '{tvne_pkg::OP_WRITE,    4,    0, 0,  8388607, -8388608, 12345, 0, 0, 0, 0,     0, 0},
    '{tvne_pkg::OP_ADD,      3, 1023, 4,        0,        0,     0, 0, 0, 0, 0,     0, 0},
    '{tvne_pkg::OP_ADD,      2,    0, 1,        0,        0,     0, 1, 0, 0, 0, 32767, 0},
    '{tvne_pkg::OP_READ,     1,    0, 0,        0,        0,     0, 0, 0, 0, 0,     0, 0},
    '{tvne_pkg::OP_READ,     5,    0, 0,        0,        0,     0, 1, 1, 0, 0,     0, 1},
    '{tvne_pkg::OP_ADD,      0,    0, 0,        0,        0,     0, 1, 0, 0, 0,     0, 1},
    '{tvne_pkg::OP_CLEAR,    0,    0, 0,        0,        0,     0, 0, 0, 0, 0,     0, 0},
    '{tvne_pkg::OP_READ,     0,    0, 0,        0,        0,     0, 1, 1, 0, 0,     0, 1},
    '{tvne_pkg::OP_READ,  1023,    0, 0,        0,        0,     0, 0, 0, 0, 0,     0, 0}
  };

  // random coordinate: half full range, half small to keep faces tame
  function automatic int rand_coord();
    if ($urandom_range(1)) return int'($signed($urandom() & 24'hFFFFFF));
    return (int'($urandom_range(2000)) - 1000) * 256;
  endfunction

  initial begin
    normal_t tn;
    int r, a, b, c, w;
    for (int i = 0; i < NVTX; i++) begin
      vtx_written[i] = 1'b0;
      sum_x[i] = 0; sum_y[i] = 0; sum_z[i] = 0;
      vtx_x[i] = 0; vtx_y[i] = 0; vtx_z[i] = 0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < N_DIR; i++) begin
      tn.kind = dir_tab[i].ekind[0];
      tn.nx = 16'(dir_tab[i].ex);
      tn.ny = 16'(dir_tab[i].ey);
      tn.nz = 16'(dir_tab[i].ez);
      tn.deg = dir_tab[i].edeg[0];
      send_request(dir_tab[i].op, dir_tab[i].a, dir_tab[i].b, dir_tab[i].c,
                   dir_tab[i].px, dir_tab[i].py, dir_tab[i].pz, dir_tab[i].typed, tn);
    end

    // one face added over and over until the corner sums saturate
    for (int i = 0; i < SAT_ADDS; i++)
      send_request(tvne_pkg::OP_ADD, 0, 1, 2, 0, 0, 0, 1'b0, tn);
    send_request(tvne_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 1'b0, tn);
    send_request(tvne_pkg::OP_READ, 2, 0, 0, 0, 0, 0, 1'b0, tn);
    send_request(tvne_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 1'b0, tn);

    // random traffic; faces only over written vertices
    for (int i = 0; i < RAND_REQS; i++) begin
      r = $urandom_range(99);
      if (r < 28 || written_list.size() < 3) begin
        a = $urandom_range(NVTX - 1);
        if ($urandom_range(9) == 0 && written_list.size() > 0) begin
          // duplicate position of another vertex
          w = written_list[$urandom_range(written_list.size() - 1)];
          send_request(tvne_pkg::OP_WRITE, a, 0, 0, vtx_x[w], vtx_y[w], vtx_z[w], 1'b0, tn);
        end else begin
          send_request(tvne_pkg::OP_WRITE, a, $urandom_range(NVTX - 1),
                       $urandom_range(NVTX - 1),
                       rand_coord(), rand_coord(), rand_coord(), 1'b0, tn);
        end
      end else if (r < 75) begin
        a = written_list[$urandom_range(written_list.size() - 1)];
        b = written_list[$urandom_range(written_list.size() - 1)];
        c = written_list[$urandom_range(written_list.size() - 1)];
        send_request(tvne_pkg::OP_ADD, a, b, c, rand_coord(), rand_coord(), rand_coord(),
                     1'b0, tn);
      end else if (r < 98) begin
        a = $urandom_range(1) ? written_list[$urandom_range(written_list.size() - 1)]
                              : int'($urandom_range(NVTX - 1));
        send_request(tvne_pkg::OP_READ, a, $urandom_range(NVTX - 1), $urandom_range(NVTX - 1),
                     rand_coord(), rand_coord(), rand_coord(), 1'b0, tn);
      end else begin
        send_request(tvne_pkg::OP_CLEAR, $urandom_range(NVTX - 1), 0, 0, 0, 0, 0, 1'b0, tn);
      end
    end
    in_valid <= 1'b0;

    // drain, then allow for a trailing clear pass
    while (pending_normals.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    if (errors == 0)
      $display("tb_triangle_vertex_normal_engine_core OK");
    else
      $display("tb_triangle_vertex_normal_engine_core NOT OK");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/tvne_pkg.sv
rtl/core/tvne_ctrl.sv
rtl/core/tvne_dpath.sv
rtl/core/triangle_vertex_normal_engine_core.sv
test/tb_triangle_vertex_normal_engine_core.sv
